@@ rtl/core/bbtb_pkg.sv @@
// ----------------------------------------------------------------------------
// bbtb_pkg: shared types and constants of the bearing and range unit
// Field widths, internal datapath widths, payload structs and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package bbtb_pkg;

    localparam int PIXEL_BITS         = 12;
    localparam int DIM_W              = 13;
    localparam int TAN_W              = 20;
    localparam int TS_W               = 16;
    localparam int ANG_W              = 16;
    localparam int RANGE_W            = 24;
    localparam int CFG_ADDR_W         = 3;
    localparam int CFG_DATA_W         = 20;
    localparam int DIV_STEPS          = RANGE_W;
    localparam int ATAN_LEN           = 24;
    localparam int CORDIC_STAGES_DEF  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TAN_HORIZ    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TAN_VERT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SIZE  = 3'd4;

    // Pixel offset from the frame center, doubled: a + b - dim.
    localparam int OFF_W   = ((PIXEL_BITS + 1 > DIM_W) ? PIXEL_BITS + 1 : DIM_W) + 1;
    localparam int PROD_W  = OFF_W + TAN_W + 1;
    localparam int CW      = PROD_W + 2;           // CORDIC x/y width with gain headroom
    localparam int ZW      = 34;                   // angle accumulator, 2^-32 turn units
    localparam int FRAC_SH = 16;                   // Q16 of the image dimension on x
    localparam int RANGE_SH = 15;
    localparam int NUM_W   = TS_W + DIM_W + RANGE_SH;
    localparam int NW      = NUM_W + 1;
    localparam int DEN_W   = TAN_W + PIXEL_BITS;
    localparam int CMP_W   = (DEN_W + DIV_STEPS > NW) ? DEN_W + DIV_STEPS : NW;

    localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] box_left;
        logic [PIXEL_BITS-1:0] box_top;
        logic [PIXEL_BITS-1:0] box_right;
        logic [PIXEL_BITS-1:0] box_bottom;
    } in_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw_angle;
        logic signed [ANG_W-1:0] pitch_angle;
        logic [RANGE_W-1:0]      range_mm;
        logic                    box_invalid;
    } out_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [TAN_W-1:0] tan_h;
        logic [TAN_W-1:0] tan_v;
        logic [TS_W-1:0]  target;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } axis_t;

    typedef struct packed {
        axis_t               h;
        axis_t               v;
        logic [NW-1:0]       rem;
        logic [DEN_W-1:0]    den;
        logic [RANGE_W-1:0]  quo;
        logic                sat;
        logic                invalid;
    } cell_t;

    // atan(2^-i) in units of 2^-32 of a full turn.
    function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = ZW'(536870912);
                1: v = ZW'(316933406);
                2: v = ZW'(167458907);
                3: v = ZW'(85004756);
                4: v = ZW'(42667331);
                5: v = ZW'(21354465);
                6: v = ZW'(10679838);
                7: v = ZW'(5340245);
                8: v = ZW'(2670163);
                9: v = ZW'(1335087);
                10: v = ZW'(667544);
                11: v = ZW'(333772);
                12: v = ZW'(166886);
                13: v = ZW'(83443);
                14: v = ZW'(41722);
                15: v = ZW'(20861);
                16: v = ZW'(10430);
                17: v = ZW'(5215);
                18: v = ZW'(2608);
                19: v = ZW'(1304);
                20: v = ZW'(652);
                21: v = ZW'(326);
                22: v = ZW'(163);
                23: v = ZW'(81);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/core/bbox_to_bearing_and_range_unit.sv @@
// ----------------------------------------------------------------------------
// bbox_to_bearing_and_range_unit: target bearing and range from a box
// Pinhole camera bearing (yaw, pitch) and range from one detection box.
// ----------------------------------------------------------------------------
// The unit takes one detection box per transaction and returns one result
// transaction holding yaw, pitch, range and an invalid-box flag. It is fully
// pipelined: a new box can be accepted every clock cycle unless every stage
// is full and the output is held. Each box passes through the prep stages,
// the cell chain and the output register, 3 + max(CORDIC_STAGES, 24) + 1
// register stages (28 at the defaults). The depth is set by the 24-step
// range division running in the cell chain beside the CORDIC rotations.
// Every stage holds a valid bit and may fill while a later stage is stalled,
// so the input keeps accepting boxes while a finished result waits on the
// output, until every stage is full. Configuration registers must only be
// written while the pipeline is empty; indexes above 4 are ignored.
// ----------------------------------------------------------------------------
module bbox_to_bearing_and_range_unit #(
    parameter int CORDIC_STAGES = bbtb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bbtb_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bbtb_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbtb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bbtb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bbtb_pkg::*;

    // One cell per division step or CORDIC rotation, whichever is more.
    localparam int NCELL = (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
    localparam int NPREP = 3;
    localparam int NST   = NPREP + NCELL + 1;

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [TAN_W-1:0] tan_horiz_reg;
    logic [TAN_W-1:0] tan_vert_reg;
    logic [TS_W-1:0]  target_size_reg;

    cfg_t             cfg;
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    logic [NST:0]     rdy;
    cell_t            chain [NCELL+1];
    out_t             out_next;
    out_t             out_reg;
    logic signed [ZW-1:0] zr_h;
    logic signed [ZW-1:0] zr_v;

    // Configuration writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= DIM_W'(640);
            image_height_reg <= DIM_W'(480);
            tan_horiz_reg    <= TAN_W'(55974);
            tan_vert_reg     <= TAN_W'(38418);
            target_size_reg  <= TS_W'(200);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_TAN_HORIZ:    tan_horiz_reg    <= cfg_data[TAN_W-1:0];
                REG_TAN_VERT:     tan_vert_reg     <= cfg_data[TAN_W-1:0];
                REG_TARGET_SIZE:  target_size_reg  <= cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero image dimension is treated as one pixel.
    always_comb begin
        cfg.width  = (image_width_reg == '0) ? DIM_W'(1) : image_width_reg;
        cfg.height = (image_height_reg == '0) ? DIM_W'(1) : image_height_reg;
        cfg.tan_h  = tan_horiz_reg;
        cfg.tan_v  = tan_vert_reg;
        cfg.target = target_size_reg;
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        rdy[NST] = m_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = s_valid;
        for (int k = 1; k < NST; k++) begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NST-1];

    bbtb_prep u_prep (
        .aclk     (aclk),
        .en       (rdy[NPREP-1:0]),
        .in_data  (s_data),
        .cfg      (cfg),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        bbtb_cell #(
            .IDX           (i),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .aclk     (aclk),
            .en       (rdy[NPREP+i]),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Round the accumulated angles half up to 16-bit binary angles, and pick
    // the range: zero for an invalid box, full scale when saturated.
    always_comb begin
        zr_h = chain[NCELL].h.z + ZW'(32768);
        zr_v = chain[NCELL].v.z + ZW'(32768);
        out_next.yaw_angle   = zr_h[FRAC_SH +: ANG_W];
        out_next.pitch_angle = zr_v[FRAC_SH +: ANG_W];
        out_next.box_invalid = chain[NCELL].invalid;
        if (chain[NCELL].invalid) begin
            out_next.range_mm = '0;
        end else if (chain[NCELL].sat) begin
            out_next.range_mm = RANGE_MAX;
        end else begin
            out_next.range_mm = chain[NCELL].quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NST-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // An invalid box always reports zero range.
    a_invalid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.box_invalid |-> m_data.range_mm == '0)
        else $error("invalid box with nonzero range");

    // The input only stalls when every stage is full and the output is held.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with room in the pipeline");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

@@ rtl/core/bbtb_prep.sv @@
// ----------------------------------------------------------------------------
// bbtb_prep: front stages ahead of the cell chain
// Forms the center offsets, box width, the tangent products, the range
// numerator and denominator, the invalid-box flag and the saturation decision.
// ----------------------------------------------------------------------------
module bbtb_prep (
    input  logic            aclk,
    input  logic [2:0]      en,
    input  bbtb_pkg::in_t   in_data,
    input  bbtb_pkg::cfg_t  cfg,
    output bbtb_pkg::cell_t cell_out
);
    import bbtb_pkg::*;

    logic [OFF_W-1:0]      off_h_reg;
    logic [OFF_W-1:0]      off_v_reg;
    logic [PIXEL_BITS-1:0] bw_reg;
    logic                  inv1_reg;

    logic signed [CW-1:0]  y_h_reg;
    logic signed [CW-1:0]  y_v_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;
    logic                  inv2_reg;

    logic signed [PROD_W-1:0] prod_h;
    logic signed [PROD_W-1:0] prod_v;
    logic [NW-1:0]            n_sum;
    cell_t                    cell_next;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            off_h_reg <= OFF_W'(in_data.box_left) + OFF_W'(in_data.box_right)
                         - OFF_W'(cfg.width);
            off_v_reg <= OFF_W'(in_data.box_top) + OFF_W'(in_data.box_bottom)
                         - OFF_W'(cfg.height);
            bw_reg    <= in_data.box_right - in_data.box_left;
            inv1_reg  <= (in_data.box_right <= in_data.box_left);
        end
    end

    always_comb begin
        prod_h = $signed(off_h_reg) * $signed({1'b0, cfg.tan_h});
        prod_v = $signed(off_v_reg) * $signed({1'b0, cfg.tan_v});
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            y_h_reg  <= CW'(prod_h);
            y_v_reg  <= CW'(prod_v);
            num_reg  <= (NUM_W'(cfg.target) * NUM_W'(cfg.width)) << RANGE_SH;
            den_reg  <= DEN_W'(cfg.tan_h) * DEN_W'(bw_reg);
            inv2_reg <= inv1_reg;
        end
    end

    always_comb begin
        n_sum              = NW'(num_reg) + NW'(den_reg >> 1);
        cell_next.h.x      = CW'(cfg.width) << FRAC_SH;
        cell_next.h.y      = y_h_reg;
        cell_next.h.z      = '0;
        cell_next.v.x      = CW'(cfg.height) << FRAC_SH;
        cell_next.v.y      = y_v_reg;
        cell_next.v.z      = '0;
        cell_next.rem      = n_sum;
        cell_next.den      = den_reg;
        cell_next.quo      = '0;
        // The quotient reaches 2^24 exactly when floor(n / 2^24) >= den.
        cell_next.sat      = (CMP_W'(n_sum >> RANGE_W) >= CMP_W'(den_reg));
        cell_next.invalid  = inv2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            cell_out <= cell_next;
        end
    end

endmodule

@@ rtl/core/bbtb_cell.sv @@
// ----------------------------------------------------------------------------
// bbtb_cell: one cell of the CORDIC and divider chain
// Performs one vectoring rotation on both axes and one restoring division
// step, each where IDX is in range, then registers it for the next cell.
// ----------------------------------------------------------------------------
module bbtb_cell #(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = bbtb_pkg::CORDIC_STAGES_DEF
) (
    input  logic            aclk,
    input  logic            en,
    input  bbtb_pkg::cell_t cell_in,
    output bbtb_pkg::cell_t cell_out
);
    import bbtb_pkg::*;

    localparam bit ROT_ON = (IDX < CORDIC_STAGES) && (IDX < ATAN_LEN);
    localparam bit DIV_ON = (IDX < DIV_STEPS);
    localparam int DIV_K  = DIV_ON ? DIV_STEPS - 1 - IDX : 0;

    function automatic axis_t rotate(input axis_t a);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        axis_t                r;
        begin
            xs = a.x >>> IDX;
            ys = a.y >>> IDX;
            if (!a.y[CW-1]) begin
                r.x = a.x + ys;
                r.y = a.y - xs;
                r.z = a.z + atan_val(IDX);
            end else begin
                r.x = a.x - ys;
                r.y = a.y + xs;
                r.z = a.z - atan_val(IDX);
            end
            return r;
        end
    endfunction

    logic [CMP_W-1:0] trial;
    cell_t            cell_next;

    always_comb begin
        cell_next = cell_in;
        trial     = CMP_W'(cell_in.den) << DIV_K;
        if (ROT_ON) begin
            cell_next.h = rotate(cell_in.h);
            cell_next.v = rotate(cell_in.v);
        end
        if (DIV_ON && (CMP_W'(cell_in.rem) >= trial)) begin
            cell_next.rem        = NW'(CMP_W'(cell_in.rem) - trial);
            cell_next.quo[DIV_K] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out <= cell_next;
        end
    end

endmodule

@@ bench/bbox_to_bearing_and_range_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbox_to_bearing_and_range_unit_test: self-checking bench of the bearing unit
// Drives detection boxes through several camera settings, predicts yaw, pitch,
// range and the invalid flag of every box, and compares each result in order.
// ----------------------------------------------------------------------------
module bbox_to_bearing_and_range_unit_test;
    import bbtb_pkg::*;

    // Cycles that a box may still spend inside the pipeline after the last
    // expected result has left, with margin over the pipeline latency.
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BOXES  = 235;
    // An index beyond the register file; the unit must ignore it.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam longint ARCTAN_STEP [ATAN_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // One pending piece of work for the driver: a box, a register write, or
    // a hold that waits until the pipeline has drained.
    typedef enum logic [1:0] { JOB_BOX, JOB_WRITE, JOB_DRAIN } job_kind_t;

    typedef struct {
        job_kind_t              kind;
        in_t                    box;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  value;
    } job_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    job_t job_q[$];
    out_t bearing_q[$];

    // The bench's own copy of the camera registers.
    logic [DIM_W-1:0] cam_width;
    logic [DIM_W-1:0] cam_height;
    logic [TAN_W-1:0] cam_tan_h;
    logic [TAN_W-1:0] cam_tan_v;
    logic [TS_W-1:0]  cam_target;

    bit box_pending;
    bit write_pending;
    int boxes_taken;
    int quiet_cycles;
    int mismatch_count;
    int cycle_count;

    bbox_to_bearing_and_range_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Vectoring CORDIC: rotate (x, y) onto the x axis and return the angle
    // in units of pi/32768, rounded half up.
    function automatic logic [ANG_W-1:0] vector_angle(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_STEP[i];
            end
        end
        z = (z + 32768) >>> 16;
        return z[ANG_W-1:0];
    endfunction

    // Angle of the box center off the optical axis along one image axis.
    function automatic logic [ANG_W-1:0] axis_bearing(longint a, longint b, longint dim,
                                                      longint tanq);
        return vector_angle(dim << FRAC_SH, (a + b - dim) * tanq);
    endfunction

    function automatic out_t predict_bearing(in_t box);
        out_t   r;
        longint w;
        longint h;
        longint den;
        longint num;
        longint rng;
        w = (cam_width == 0) ? 1 : longint'(cam_width);
        h = (cam_height == 0) ? 1 : longint'(cam_height);
        r.box_invalid = (box.box_right <= box.box_left);
        if (r.box_invalid) begin
            rng = 0;
        end else begin
            den = longint'(cam_tan_h) * longint'(box.box_right - box.box_left);
            if (den == 0) begin
                rng = RANGE_MAX;
            end else begin
                num = longint'(cam_target) * w * 32768;
                rng = (num + den / 2) / den;
                if (rng > RANGE_MAX) rng = RANGE_MAX;
            end
        end
        r.range_mm    = rng[RANGE_W-1:0];
        r.yaw_angle   = axis_bearing(box.box_left, box.box_right, w, cam_tan_h);
        r.pitch_angle = axis_bearing(box.box_top, box.box_bottom, h, cam_tan_v);
        return r;
    endfunction

    function automatic in_t make_box(int l, int t, int r, int b);
        in_t x;
        x.box_left   = PIXEL_BITS'(l);
        x.box_top    = PIXEL_BITS'(t);
        x.box_right  = PIXEL_BITS'(r);
        x.box_bottom = PIXEL_BITS'(b);
        return x;
    endfunction

    task automatic queue_box(in_t box);
        job_t j;
        j.kind = JOB_BOX;
        j.box  = box;
        job_q.push_back(j);
    endtask

    task automatic queue_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        job_t j;
        j.kind  = JOB_WRITE;
        j.addr  = addr;
        j.value = value;
        job_q.push_back(j);
    endtask

    task automatic queue_camera(int w, int h, int th, int tv, int ts);
        queue_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        queue_write(REG_TAN_HORIZ, CFG_DATA_W'(th));
        queue_write(REG_TAN_VERT, CFG_DATA_W'(tv));
        queue_write(REG_TARGET_SIZE, CFG_DATA_W'(ts));
    endtask

    // Mostly well-formed boxes with the right edge past the left one, some
    // thin boxes, and some fully random edges that may be inverted.
    task automatic queue_random_boxes(int count);
        int pick;
        int l;
        int t;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                l = $urandom_range(4094);
                t = $urandom_range(4095);
                queue_box(make_box(l, t, $urandom_range(4095, l + 1), $urandom_range(4095)));
            end else if (pick < 80) begin
                l = $urandom_range(4090);
                t = $urandom_range(4095);
                queue_box(make_box(l, t, l + $urandom_range(5), $urandom_range(4095)));
            end else begin
                queue_box(make_box($urandom_range(4095), $urandom_range(4095),
                                   $urandom_range(4095), $urandom_range(4095)));
            end
        end
    endtask

    // Stimulus plan. Camera writes and drain holds are only acted on by the
    // driver once the pipeline is empty.
    initial begin
        job_t hold;
        hold.kind = JOB_DRAIN;

        // Directed boxes at the reset camera: extremes of every edge, empty
        // and inverted boxes, one-pixel boxes and the centered frame.
        queue_box(make_box(0, 0, 0, 0));
        queue_box(make_box(4095, 4095, 4095, 4095));
        queue_box(make_box(0, 0, 4095, 4095));
        queue_box(make_box(4095, 0, 0, 4095));
        queue_box(make_box(100, 100, 100, 200));
        queue_box(make_box(319, 239, 320, 240));
        queue_box(make_box(0, 0, 640, 480));
        queue_box(make_box(0, 0, 1, 1));
        queue_box(make_box(4094, 4094, 4095, 4095));
        queue_box(make_box(2730, 1365, 1365, 2730));
        queue_box(make_box(600, 400, 640, 480));
        queue_box(make_box(0, 0, 40, 40));
        queue_random_boxes(RANDOM_BOXES);

        // Unknown register first: it must leave the reset camera alone.
        queue_write(REG_UNUSED, 20'hFFFFF);
        queue_box(make_box(10, 10, 20, 20));
        queue_camera(1920, 1080, 65536, 40000, 1750);
        queue_random_boxes(RANDOM_BOXES / 2);
        // Hold the sender until every outstanding result has come back.
        job_q.push_back(hold);
        queue_random_boxes(RANDOM_BOXES / 2);

        // Zero dimensions read as one, zero tangent saturates the range.
        queue_camera(0, 0, 0, 0, 0);
        queue_box(make_box(0, 0, 1, 1));
        queue_box(make_box(5, 5, 5, 5));
        queue_random_boxes(RANDOM_BOXES);

        // Upper extremes, with data wider than the registers.
        queue_camera(20'hFFFFF, 8191, 1048575, 1048575, 65535);
        queue_box(make_box(0, 0, 1, 1));
        queue_box(make_box(0, 0, 4095, 4095));
        queue_random_boxes(RANDOM_BOXES);

        // Smallest legal settings: a one-pixel frame, unit tangents and a unit target.
        queue_camera(1, 1, 1, 1, 1);
        queue_box(make_box(0, 0, 1, 1));
        queue_random_boxes(RANDOM_BOXES);

        queue_camera(4096, 4096, 32768, 16384, 500);
        queue_random_boxes(RANDOM_BOXES / 2);
        queue_camera($urandom_range(4096, 1), $urandom_range(4096, 1),
                     $urandom_range(1048575, 1), $urandom_range(1048575, 1),
                     $urandom_range(65535, 1));
        queue_random_boxes(RANDOM_BOXES / 2);

        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (job_q.size() == 0 && !box_pending && !write_pending);
        wait (bearing_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Idling is switched off while boxes 300 to 599 are taken.
    function automatic bit take_break();
        if (boxes_taken >= 300 && boxes_taken < 600) return 1'b0;
        return $urandom_range(99) < 12;
    endfunction

    // Driver: the handshake and data inputs change on the falling edge only.
    initial begin
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
    end

    always @(negedge aclk) begin
        job_t head;
        m_ready <= aresetn && !take_break();
        if (aresetn && !box_pending && !write_pending && job_q.size() > 0) begin
            head = job_q[0];
            case (head.kind)
                JOB_BOX: begin
                    if (!take_break()) begin
                        void'(job_q.pop_front());
                        s_valid     <= 1'b1;
                        s_data      <= head.box;
                        box_pending  = 1'b1;
                    end else begin
                        s_valid <= 1'b0;
                    end
                end
                JOB_WRITE: begin
                    s_valid <= 1'b0;
                    if (bearing_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        void'(job_q.pop_front());
                        cfg_valid     <= 1'b1;
                        cfg_addr      <= head.addr;
                        cfg_data      <= head.value;
                        write_pending  = 1'b1;
                    end
                end
                default: begin
                    s_valid <= 1'b0;
                    if (bearing_q.size() == 0) void'(job_q.pop_front());
                end
            endcase
        end else if (!box_pending) begin
            s_valid <= 1'b0;
        end
        if (!write_pending) cfg_valid <= 1'b0;
    end

    // Acceptance, prediction and checking, all on the rising edge.
    always @(posedge aclk) begin
        out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (!aresetn) begin
            cam_width      = DIM_W'(640);
            cam_height     = DIM_W'(480);
            cam_tan_h      = TAN_W'(55974);
            cam_tan_v      = TAN_W'(38418);
            cam_target     = TS_W'(200);
            quiet_cycles   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  cam_width  = cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: cam_height = cfg_data[DIM_W-1:0];
                    REG_TAN_HORIZ:    cam_tan_h  = cfg_data[TAN_W-1:0];
                    REG_TAN_VERT:     cam_tan_v  = cfg_data[TAN_W-1:0];
                    REG_TARGET_SIZE:  cam_target = cfg_data[TS_W-1:0];
                    default: ;
                endcase
                write_pending = 1'b0;
            end
            if (s_valid && s_ready) begin
                bearing_q.push_back(predict_bearing(s_data));
                boxes_taken++;
                box_pending = 1'b0;
            end
            if (m_valid && m_ready) begin
                if (bearing_q.size() == 0) begin
                    $error("result transaction with no box outstanding");
                    mismatch_count++;
                end else begin
                    want = bearing_q.pop_front();
                    if (m_data.yaw_angle !== want.yaw_angle) begin
                        $error("yaw_angle expected %0d actual %0d",
                               want.yaw_angle, m_data.yaw_angle);
                        mismatch_count++;
                    end
                    if (m_data.pitch_angle !== want.pitch_angle) begin
                        $error("pitch_angle expected %0d actual %0d",
                               want.pitch_angle, m_data.pitch_angle);
                        mismatch_count++;
                    end
                    if (m_data.range_mm !== want.range_mm) begin
                        $error("range_mm expected %0d actual %0d",
                               want.range_mm, m_data.range_mm);
                        mismatch_count++;
                    end
                    if (m_data.box_invalid !== want.box_invalid) begin
                        $error("box_invalid expected %0d actual %0d",
                               want.box_invalid, m_data.box_invalid);
                        mismatch_count++;
                    end
                end
            end
            // Count cycles with nothing in flight so a write never lands
            // while a box is still inside the pipeline.
            if (bearing_q.size() == 0 && !s_valid) quiet_cycles++;
            else quiet_cycles = 0;
        end
    end

endmodule

@@ bbox_to_bearing_and_range_unit.f @@
rtl/core/bbtb_pkg.sv
rtl/core/bbtb_prep.sv
rtl/core/bbtb_cell.sv
rtl/core/bbox_to_bearing_and_range_unit.sv
bench/bbox_to_bearing_and_range_unit_test.sv
